@@ rtl/core/crc64c_pkg.sv @@
// ============================================================================
// crc64c_pkg
// Shared types and constants for the CRC-64 combine block.
// ============================================================================
package crc64c_pkg;

  localparam int unsigned CRC_W   = 64;
  localparam int unsigned LANE_W  = 8;   // multiplier bits consumed per cycle
  localparam int unsigned CNT_W   = $clog2(CRC_W / LANE_W);

  localparam logic [CRC_W-1:0] POLY_XZ   = 64'hC96C_5795_D787_0F42;
  localparam logic [CRC_W-1:0] POLY_NVME = 64'h9A6C_9329_AC4B_C9B5;

  // x^8 in reflected form (x^0 sits at the MSB)
  localparam logic [CRC_W-1:0] X8_REFL   = 64'h0080_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
  } dp_status_t;

endpackage

@@ rtl/core/crc64c_datapath.sv @@
// ============================================================================
// crc64c_datapath
// Operand registers and a pair of digit-serial GF(2) modular multipliers.
// Per length bit: s = s*s and c = c*s if set; mod P, eight bits a cycle.
// ============================================================================
module crc64c_datapath (
  input  logic                            clk_i,
  input  logic                            variant_i,
  input  crc64c_pkg::dp_cmd_t             cmd_i,
  output crc64c_pkg::dp_status_t          status_o,
  input  logic [crc64c_pkg::CRC_W-1:0]    first_crc_i,
  input  logic [crc64c_pkg::CRC_W-1:0]    second_crc_i,
  input  logic [crc64c_pkg::CRC_W-1:0]    second_length_i,
  output logic [crc64c_pkg::CRC_W-1:0]    combined_crc_o
);
  import crc64c_pkg::*;

  logic [CRC_W-1:0] poly_q;
  logic [CRC_W-1:0] c_q, c2_q, len_q, s_q;
  logic [CRC_W-1:0] a_q, pc_q, ps_q, bc_q, bs_q;
  logic [CRC_W-1:0] pc_d, ps_d, bc_d, bs_d;
  logic [CRC_W-1:0] result_q;

  // multiply by x in reflected form
  function automatic logic [CRC_W-1:0] mul_x(input logic [CRC_W-1:0] v,
                                             input logic [CRC_W-1:0] poly);
    mul_x = (v >> 1) ^ (v[0] ? poly : '0);
  endfunction

  always_comb begin
    pc_d = pc_q;
    ps_d = ps_q;
    bc_d = bc_q;
    bs_d = bs_q;
    for (int j = 0; j < LANE_W; j++) begin
      if (a_q[CRC_W-1-j]) begin
        pc_d = pc_d ^ bc_d;
        ps_d = ps_d ^ bs_d;
      end
      bc_d = mul_x(bc_d, poly_q);
      bs_d = mul_x(bs_d, poly_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q    <= first_crc_i;
      c2_q   <= (second_length_i == '0) ? '0 : second_crc_i;
      len_q  <= second_length_i;
      s_q    <= X8_REFL;
      poly_q <= variant_i ? POLY_NVME : POLY_XZ;
    end
    if (cmd_i.start) begin
      a_q  <= s_q;
      pc_q <= '0;
      ps_q <= '0;
      bc_q <= c_q;
      bs_q <= s_q;
    end
    if (cmd_i.step) begin
      a_q  <= a_q << LANE_W;
      pc_q <= pc_d;
      ps_q <= ps_d;
      bc_q <= bc_d;
      bs_q <= bs_d;
    end
    if (cmd_i.commit) begin
      if (len_q[0]) begin
        c_q <= pc_d;
      end
      s_q   <= ps_d;
      len_q <= len_q >> 1;
    end
    if (cmd_i.push) begin
      result_q <= c_q ^ c2_q;
    end
  end

  assign status_o.len_zero = (len_q == '0);
  assign combined_crc_o    = result_q;

endmodule

@@ rtl/core/crc64c_ctrl.sv @@
// ============================================================================
// crc64c_ctrl
// Sequencer for the combine: walks the length bits, runs the multiply steps
// for each bit and hands the result to the output register.
// ============================================================================
module crc64c_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output crc64c_pkg::dp_cmd_t    cmd_o,
  input  crc64c_pkg::dp_status_t status_i
);
  import crc64c_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             last_cnt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_cnt = (cnt_q == CNT_W'(CRC_W / LANE_W - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.len_zero) begin
          state_d = ST_MUL;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (last_cnt) state_d = ST_CHECK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.start = !status_i.len_zero;
        cmd_o.push  = status_i.len_zero && out_free;
      end
      ST_MUL: begin
        cmd_o.step   = 1'b1;
        cmd_o.commit = last_cnt;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = (state_q == ST_MUL) ? cnt_q + 1'b1 : '0;
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/crc64_combine_top.sv @@
// ============================================================================
// crc64_combine_top
// CRC-64 combine: CRC(A||B) from CRC(A), CRC(B) and the byte length of B.
// ============================================================================
// Input channel: in_valid_i / in_stall_o carry one word of first_crc_i,
// second_crc_i and second_length_i. Output channel: out_valid_o /
// out_stall_i carry combined_crc_o. A word moves on a clock edge with valid
// high and stall low.
// cfg_we_i writes cfg_wdata_i into the polynomial select (0 = XZ, 1 = NVME);
// the choice is sampled when an input word is taken.
// One word is processed at a time. Each length bit up to the highest set
// bit costs one check and a run of multiply steps, in which two
// digit-serial GF(2) mod-P multipliers consume 8 operand bits a cycle.
// out_valid_o rises once a check finds the length exhausted and the
// output register is free. A zero length is pushed from the first check
// and returns first_crc_i. A new input word is taken only once the
// sequencer is back in idle.
// The result sits in an output register, so a new input word is taken while
// the previous result waits on out_stall_i; the next result is held back in
// the controller until that register frees.
// Reset clears the sequencer, the output valid and the select (XZ).
// ============================================================================
module crc64_combine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [crc64c_pkg::CRC_W-1:0]  first_crc_i,
  input  logic [crc64c_pkg::CRC_W-1:0]  second_crc_i,
  input  logic [crc64c_pkg::CRC_W-1:0]  second_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [crc64c_pkg::CRC_W-1:0]  combined_crc_o
);
  import crc64c_pkg::*;

  logic       variant_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  crc64c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  crc64c_datapath u_datapath (
    .clk_i           (clk_i),
    .variant_i       (variant_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .first_crc_i     (first_crc_i),
    .second_crc_i    (second_crc_i),
    .second_length_i (second_length_i),
    .combined_crc_o  (combined_crc_o)
  );

endmodule
